// ===== rtl/sorted_max_priority_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Sorted max-priority queue: assertion macros
// Clocked implication checks used by the queue's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef SORTED_MAX_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_MAX_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMPQ_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMPQ_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/smpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted max-priority queue: package
// Operation codes and the control bundle broadcast to every cell.
// ----------------------------------------------------------------------------
package smpq_pkg;

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } kind_t;

    // Operation applied to the whole row in the current cycle.
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

// ===== rtl/smpq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted max-priority queue: storage cell
// One slot of the descending row. On a push the cell keeps its entry, takes
// the new value or takes its left neighbour's entry; on a pop it takes its
// right neighbour's entry.
// ----------------------------------------------------------------------------
module smpq_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  smpq_pkg::cell_ctrl_t    ctrl,
    input  logic [VALUE_WIDTH-1:0]  weight,
    input  logic [VALUE_WIDTH-1:0]  left_value,
    input  logic                    left_valid,
    input  logic                    left_keep,
    input  logic [VALUE_WIDTH-1:0]  right_value,
    input  logic                    right_valid,
    output logic [VALUE_WIDTH-1:0]  value,
    output logic                    valid,
    output logic                    keep
);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   valid_reg;
    logic                   valid_next;

    // Strictly greater: an equal incoming value goes ahead of this entry.
    assign keep = valid_reg && ($signed(value_reg) > $signed(weight));

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        priority if (ctrl.push) begin
            valid_next = left_valid;
            priority if (keep) begin
                value_next = value_reg;
            end else if (left_keep) begin
                value_next = weight;
            end else begin
                value_next = left_value;
            end
        end else if (ctrl.pop) begin
            value_next = right_value;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

// ===== rtl/sorted_max_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted max-priority queue: top level
// Row of DEPTH compare-and-shift cells holding signed values largest first.
// ----------------------------------------------------------------------------
// The queue takes one push or pop per clock cycle and returns its result in the
// cycle after the input beat is accepted. Every cell compares its own entry
// with the incoming value in parallel and moves at most one slot, so an
// insert or a pop completes in the accepting cycle; s_ready drops only while
// a result beat waits on m_ready. The result fields are read straight from
// the head cell and the count register, which cannot change until that beat
// has gone. A push to a full queue and a pop from an empty queue leave the
// contents alone and set m_rejected; an empty queue reports a top value of
// all ones (-1). m_count carries the low five bits of the stored count.
// ----------------------------------------------------------------------------
`include "sorted_max_priority_queue_assert.svh"

module sorted_max_priority_queue #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_kind,
    input  logic signed [VALUE_WIDTH-1:0]  s_weight,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [VALUE_WIDTH-1:0]  m_top_value,
    output logic [4:0]                     m_count,
    output logic                           m_is_empty,
    output logic                           m_is_full,
    output logic                           m_rejected
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                    accept;
    logic                    is_pop;
    logic                    full;
    logic                    empty;
    smpq_pkg::cell_ctrl_t    ctrl;

    logic [VALUE_WIDTH-1:0]  cell_value [DEPTH];
    logic [DEPTH-1:0]        cell_valid;
    logic [DEPTH-1:0]        cell_keep;

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CNT_W+4:0]        count_ext;
    logic                    m_valid_reg;
    logic                    m_rejected_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign is_pop  = (smpq_pkg::kind_t'(s_kind) == smpq_pkg::KIND_POP);
    assign full    = cell_valid[DEPTH-1];
    assign empty   = !cell_valid[0];

    assign ctrl.push = accept && !is_pop && !full;
    assign ctrl.pop  = accept && is_pop && !empty;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            logic [VALUE_WIDTH-1:0] left_value;
            logic                   left_valid;
            logic                   left_keep;
            logic [VALUE_WIDTH-1:0] right_value;
            logic                   right_valid;

            if (i == 0) begin : g_head
                // Head slot always fills on a push.
                assign left_value = s_weight;
                assign left_valid = 1'b1;
                assign left_keep  = 1'b0;
            end else begin : g_body
                assign left_value = cell_value[i-1];
                assign left_valid = cell_valid[i-1];
                assign left_keep  = cell_keep[i-1];
            end

            if (i == DEPTH - 1) begin : g_tail
                // Tail slot empties on a pop.
                assign right_value = s_weight;
                assign right_valid = 1'b0;
            end else begin : g_inner
                assign right_value = cell_value[i+1];
                assign right_valid = cell_valid[i+1];
            end

            smpq_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .weight      (s_weight),
                .left_value  (left_value),
                .left_valid  (left_valid),
                .left_keep   (left_keep),
                .right_value (right_value),
                .right_valid (right_valid),
                .value       (cell_value[i]),
                .valid       (cell_valid[i]),
                .keep        (cell_keep[i])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        priority if (ctrl.push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
            m_rejected_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg    <= 1'b1;
                m_rejected_reg <= is_pop ? empty : full;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Contents hold while a result beat waits, so read them directly.
    assign count_ext   = (CNT_W + 5)'(count_reg);
    assign m_valid     = m_valid_reg;
    assign m_top_value = cell_valid[0] ? cell_value[0] : '1;
    assign m_count     = count_ext[4:0];
    assign m_is_empty  = empty;
    assign m_is_full   = full;
    assign m_rejected  = m_rejected_reg;

    `SMPQ_ASSERT_IMP(a_empty_count, aclk, aresetn, 1'b1,
        (count_reg == '0) == empty, "head valid disagrees with count")
    `SMPQ_ASSERT_IMP(a_full_count, aclk, aresetn, 1'b1,
        (count_reg == CNT_W'(DEPTH)) == full, "tail valid disagrees with count")
    `SMPQ_ASSERT_NEXT(a_push_grows, aclk, aresetn, ctrl.push,
        count_reg == $past(count_reg) + CNT_W'(1), "push did not grow the queue")
    `SMPQ_ASSERT_NEXT(a_reject_flag, aclk, aresetn, accept && (is_pop ? empty : full),
        m_valid && m_rejected && $stable(count_reg), "refused beat not flagged")

    generate
        for (i = 0; i + 1 < DEPTH; i++) begin : g_order_chk
            `SMPQ_ASSERT_IMP(a_sorted, aclk, aresetn, cell_valid[i+1],
                cell_valid[i] && ($signed(cell_value[i]) >= $signed(cell_value[i+1])),
                "row out of order")
        end
    endgenerate

endmodule

// ===== sim/sorted_max_priority_queue_tb.sv =====
// ----------------------------------------------------------------------------
// Sorted max-priority queue: testbench
// Drives push and pop beats with random gaps and checks every result beat
// against a shadow copy of the sorted contents. The shadow copy covers
// ordering, equal values, full and empty refusals and the flags.
// ----------------------------------------------------------------------------
module sorted_max_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 16;
    localparam int VALUE_WIDTH  = 32;
    localparam int RANDOM_OPS   = 1300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_PRINTS   = 40;

    typedef logic signed [VALUE_WIDTH-1:0] weight_t;

    typedef struct {
        smpq_pkg::kind_t kind;
        weight_t         weight;
    } queue_op_t;

    typedef struct {
        weight_t    top_value;
        logic [4:0] count;
        logic       is_empty;
        logic       is_full;
        logic       rejected;
    } queue_status_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic       s_kind      = 1'b0;
    weight_t    s_weight    = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    weight_t    m_top_value;
    logic [4:0] m_count;
    logic       m_is_empty;
    logic       m_is_full;
    logic       m_rejected;

    queue_op_t     pending_ops[$];
    queue_status_t expected_status[$];

    weight_t shadow_vals[DEPTH];
    int      shadow_count = 0;
    int      mismatches   = 0;
    int      issued_ops   = 0;
    int      cycles       = 0;

    sorted_max_priority_queue #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_weight    (s_weight),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_top_value (m_top_value),
        .m_count     (m_count),
        .m_is_empty  (m_is_empty),
        .m_is_full   (m_is_full),
        .m_rejected  (m_rejected)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    // Apply one operation to the shadow list and return the status it leaves.
    function automatic queue_status_t apply_queue_op(smpq_pkg::kind_t kind, weight_t weight);
        queue_status_t st;
        int            pos;
        st.rejected = 1'b0;
        if (kind == smpq_pkg::KIND_PUSH) begin
            if (shadow_count >= DEPTH) begin
                st.rejected = 1'b1;
            end else begin
                // New value goes ahead of every stored value not greater than it
                pos = 0;
                while (pos < shadow_count && shadow_vals[pos] > weight) pos++;
                for (int i = shadow_count; i > pos; i--) shadow_vals[i] = shadow_vals[i-1];
                shadow_vals[pos] = weight;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                st.rejected = 1'b1;
            end else begin
                for (int i = 0; i + 1 < shadow_count; i++) shadow_vals[i] = shadow_vals[i+1];
                shadow_count--;
            end
        end
        st.top_value = (shadow_count == 0) ? weight_t'(-1) : shadow_vals[0];
        st.count     = shadow_count[4:0];
        st.is_empty  = (shadow_count == 0);
        st.is_full   = (shadow_count >= DEPTH);
        return st;
    endfunction

    // Driver: advance to the next beat once the current one is taken.
    always @(posedge aclk) begin : op_driver
        queue_op_t op;
        if (aresetn && (!s_valid || s_ready)) begin
            if (pending_ops.size() != 0 &&
                ((issued_ops >= 600 && issued_ops < 850) || $urandom_range(99) >= 32)) begin
                op = pending_ops.pop_front();
                s_valid    <= 1'b1;
                s_kind     <= op.kind;
                s_weight   <= op.weight;
                issued_ops <= issued_ops + 1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, one quiet stretch and one long hold-off.
    always @(posedge aclk) begin : ready_gen
        int rx_cycles;
        int hold_left;
        if (aresetn) begin
            rx_cycles = rx_cycles + 1;
            if (rx_cycles == 1500) hold_left = 400;
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (rx_cycles >= 700 && rx_cycles < 1100) || $urandom_range(99) >= 32;
            end
        end else begin
            rx_cycles = 0;
            hold_left = 0;
        end
    end

    // Monitor: check the result beat first, then record the accepted input beat.
    always @(posedge aclk) begin : result_check
        queue_status_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    report_mismatch("result beat with no operation outstanding");
                end else begin
                    want = expected_status.pop_front();
                    if (m_top_value !== want.top_value)
                        report_mismatch($sformatf("top_value %0d, expected %0d",
                                                  m_top_value, want.top_value));
                    if (m_count !== want.count)
                        report_mismatch($sformatf("count %0d, expected %0d",
                                                  m_count, want.count));
                    if (m_is_empty !== want.is_empty)
                        report_mismatch($sformatf("is_empty %b, expected %b",
                                                  m_is_empty, want.is_empty));
                    if (m_is_full !== want.is_full)
                        report_mismatch($sformatf("is_full %b, expected %b",
                                                  m_is_full, want.is_full));
                    if (m_rejected !== want.rejected)
                        report_mismatch($sformatf("rejected %b, expected %b",
                                                  m_rejected, want.rejected));
                end
            end
            if (s_valid && s_ready) begin
                expected_status.push_back(apply_queue_op(smpq_pkg::kind_t'(s_kind), s_weight));
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic add_op(input smpq_pkg::kind_t kind, input weight_t weight);
        queue_op_t op;
        op.kind   = kind;
        op.weight = weight;
        pending_ops.push_back(op);
    endtask

    // Bias towards a narrow band so that equal values turn up often.
    function automatic weight_t pick_weight();
        int sel;
        sel = $urandom_range(99);
        if (sel < 30) return weight_t'($urandom_range(8)) - weight_t'(4);
        if (sel < 40) begin
            case ($urandom_range(3))
                0:       return 32'sh7FFF_FFFF;
                1:       return 32'sh8000_0000;
                2:       return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        return weight_t'($urandom());
    endfunction

    initial begin
        int generated;
        int n_push;
        int n_pop;

        // Directed: empty pop, extremes, equal values, drain past empty
        add_op(smpq_pkg::KIND_POP,  32'sh1234_5678);
        add_op(smpq_pkg::KIND_PUSH, 32'sh8000_0000);
        add_op(smpq_pkg::KIND_PUSH, 32'sh7FFF_FFFF);
        add_op(smpq_pkg::KIND_PUSH, -32'sd1);
        add_op(smpq_pkg::KIND_PUSH, 32'sd0);
        add_op(smpq_pkg::KIND_PUSH, -32'sd1);
        add_op(smpq_pkg::KIND_PUSH, 32'sh7FFF_FFFF);
        add_op(smpq_pkg::KIND_POP,  32'shFFFF_FFFF);
        add_op(smpq_pkg::KIND_POP,  32'sd0);
        add_op(smpq_pkg::KIND_POP,  32'sh5555_5555);
        add_op(smpq_pkg::KIND_POP,  32'shAAAA_AAAA);
        add_op(smpq_pkg::KIND_POP,  32'sd0);
        add_op(smpq_pkg::KIND_POP,  32'sd0);
        add_op(smpq_pkg::KIND_POP,  32'sd0);

        generated = 0;
        while (generated < RANDOM_OPS) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    // Fill towards or past full, then drain towards or past empty
                    n_push = $urandom_range(20, 12);
                    n_pop  = $urandom_range(n_push + 3, n_push - 4);
                    repeat (n_push) add_op(smpq_pkg::KIND_PUSH, pick_weight());
                    repeat (n_pop) add_op(smpq_pkg::KIND_POP, weight_t'($urandom()));
                    generated += n_push + n_pop;
                end
                4, 5, 6, 7: begin
                    repeat (30) begin
                        if ($urandom_range(99) < 55) add_op(smpq_pkg::KIND_PUSH, pick_weight());
                        else add_op(smpq_pkg::KIND_POP, weight_t'($urandom()));
                    end
                    generated += 30;
                end
                default: begin
                    repeat (10) add_op(smpq_pkg::kind_t'($urandom_range(1)),
                                       weight_t'($urandom()));
                    generated += 10;
                end
            endcase
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_ops.size() != 0 || s_valid || expected_status.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
